>>> rtl/core/iptl_pkg.sv
// shared types, constants and helpers of the ipv4 prefix table
`timescale 1ns / 1ps

package iptl_pkg;

	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 6;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// longest legal prefix length
	localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 2'd0,
		KIND_DEL   = 2'd1,
		KIND_CHECK = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LEN  = 2'd1,
		ST_MISS     = 2'd2,
		ST_CAPACITY = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] prefix_base;
		logic [LEN_W-1:0]  prefix_length;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_SCAN,
		MODE_DOWN,
		MODE_UP
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT_DN,
		S_INSERT,
		S_SHIFT_UP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    latch_req;
		logic    start_scan;
		logic    start_dn;
		logic    start_up;
		logic    write_new;
		logic    count_inc;
		logic    count_dec;
		logic    load_rsp;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              len_bad;
		logic              count_zero;
		logic              count_full;
		logic              busy;
		logic              hit;
		logic              rsp_free;
	} sts_t;

	// n most significant bits set
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] sh;
		sh = LEN_MAX - len;
		if (len == '0) begin
			return '0;
		end else if (len >= LEN_MAX) begin
			return '1;
		end else begin
			return {ADDR_W{1'b1}} << sh;
		end
	endfunction

endpackage

>>> rtl/core/iptl_req_if.sv
// request channel of the ipv4 prefix table
`timescale 1ns / 1ps

interface iptl_req_if;
	import iptl_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] prefix_base;
	logic [LEN_W-1:0]  prefix_length;
	logic [ADDR_W-1:0] address;

	modport source (output valid, kind, prefix_base, prefix_length, address, input ready);
	modport sink (input valid, kind, prefix_base, prefix_length, address, output ready);
endinterface

>>> rtl/core/iptl_rsp_if.sv
// result channel of the ipv4 prefix table
`timescale 1ns / 1ps

interface iptl_rsp_if;
	import iptl_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [LEN_W-1:0]    match_length;

	modport source (output valid, status, found, match_length, input ready);
	modport sink (input valid, status, found, match_length, output ready);
endinterface

>>> rtl/core/ipv4_prefix_table_lpm.sv
// top level of the ipv4 longest prefix match table
`timescale 1ns / 1ps

// one request at a time, the next accepted the cycle after the result is loaded,
//   set by the single ram read port walking the table
// reset: arst_n clears the entry count, the controller and the result valid; table ram
//   contents are left as they are and never read before written (no clearing pass)
module ipv4_prefix_table_lpm #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	iptl_req_if.sink   req,
	iptl_rsp_if.source rsp
);
	import iptl_pkg::*;

	// command and status between the controller and the datapath
	cmd_t cmd;
	sts_t sts;
	req_t req_payload;

	// request fields packed for the datapath latch
	assign req_payload.kind          = req.kind;
	assign req_payload.prefix_base   = req.prefix_base;
	assign req_payload.prefix_length = req.prefix_length;
	assign req_payload.address       = req.address;

	// sequencer: decode, scan, shift, insert, then hand the result to the output register
	iptl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// entry ram, scan and shift engine, output register
	iptl_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_payload),
		.cmd             (cmd),
		.sts             (sts),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_found       (rsp.found),
		.rsp_match_length(rsp.match_length)
	);
endmodule

>>> rtl/core/iptl_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module iptl_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/iptl_ctrl.sv
// controller state machine of the ipv4 prefix table
`timescale 1ns / 1ps

module iptl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  iptl_pkg::sts_t sts,
	output iptl_pkg::cmd_t cmd
);
	import iptl_pkg::*;

	state_t  state_q, state_d;
	status_t status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d  = S_DECODE;
					status_d = ST_OK;
				end
			end
			S_DECODE: begin
				unique case (sts.kind)
					KIND_CHECK: state_d = S_SCAN;
					KIND_ADD: begin
						if (sts.len_bad) begin
							status_d = ST_BAD_LEN;
							state_d  = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end
					KIND_DEL: begin
						if (sts.len_bad) begin
							status_d = ST_BAD_LEN;
							state_d  = S_DONE;
						end else if (sts.count_zero) begin
							status_d = ST_CAPACITY;
							state_d  = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (!sts.busy) begin
					unique case (sts.kind)
						KIND_ADD: begin
							if (sts.hit) begin
								status_d = ST_MISS;
								state_d  = S_DONE;
							end else if (sts.count_full) begin
								status_d = ST_CAPACITY;
								state_d  = S_DONE;
							end else begin
								state_d = S_SHIFT_DN;
							end
						end
						KIND_DEL: begin
							if (sts.hit) begin
								state_d = S_SHIFT_UP;
							end else begin
								status_d = ST_MISS;
								state_d  = S_DONE;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SHIFT_DN: begin
				if (!sts.busy) begin
					state_d = S_INSERT;
				end
			end
			S_INSERT: state_d = S_DONE;
			S_SHIFT_UP: begin
				if (!sts.busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.latch_req = in_valid;
			end
			S_DECODE: begin
				unique case (sts.kind)
					KIND_CHECK: cmd.start_scan = 1'b1;
					KIND_ADD:   cmd.start_scan = !sts.len_bad;
					KIND_DEL:   cmd.start_scan = !sts.len_bad && !sts.count_zero;
					default:    cmd.start_scan = 1'b0;
				endcase
			end
			S_SCAN: begin
				if (!sts.busy) begin
					cmd.start_dn = (sts.kind == KIND_ADD) && !sts.hit && !sts.count_full;
					cmd.start_up = (sts.kind == KIND_DEL) && sts.hit;
				end
			end
			S_SHIFT_DN: cmd.start_dn = 1'b0;
			S_INSERT: begin
				cmd.write_new = 1'b1;
				cmd.count_inc = 1'b1;
			end
			S_SHIFT_UP: cmd.count_dec = !sts.busy;
			S_DONE:     cmd.load_rsp = sts.rsp_free;
			default:    cmd.load_rsp = 1'b0;
		endcase
	end

`ifndef SYNTH
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted request did not move to decode");

	a_insert_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT) |=> (state_q == S_DONE))
		else $error("insert step did not finish the request");

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start_scan, cmd.start_dn, cmd.start_up}))
		else $error("more than one engine start in a cycle");
`endif
endmodule

>>> rtl/core/iptl_dp.sv
// datapath of the ipv4 prefix table: entry ram, scan and shift engine, result register
`timescale 1ns / 1ps

module iptl_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  iptl_pkg::req_t                  req,
	input  iptl_pkg::cmd_t                  cmd,
	output iptl_pkg::sts_t                  sts,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic [iptl_pkg::STATUS_W-1:0]   rsp_status,
	output logic                            rsp_found,
	output logic [iptl_pkg::LEN_W-1:0]      rsp_match_length
);
	import iptl_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// latched request
	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] base_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] addr_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q, idx_d, idx_m1;
	logic [CW-1:0] pos_q;
	mode_t         mode_q, mode_d;
	logic          hit_q, pos_found_q;
	logic [LEN_W-1:0] hit_len_q;

	logic          rd_valid_s1;
	logic [IW-1:0] rd_idx_s1;

	logic               we, issue;
	logic [IW-1:0]      waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	entry_t             ent;
	logic               exact, masked, match, stop_now, shorter;

	logic          rsp_valid_q, rsp_found_q;
	status_t       rsp_status_q;
	logic [LEN_W-1:0] rsp_mlen_q;

	iptl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign ent      = entry_t'(rdata);
	assign exact    = (ent.base == base_q) && (ent.len == len_q);
	assign masked   = ((addr_q & prefix_mask(ent.len)) == ent.base);
	assign match    = (kind_q == KIND_CHECK) ? masked : exact;
	assign stop_now = (mode_q == MODE_SCAN) && rd_valid_s1 && match;
	assign shorter  = (mode_q == MODE_SCAN) && rd_valid_s1 && (kind_q == KIND_ADD)
		&& !pos_found_q && (ent.len < len_q);
	assign idx_m1   = idx_q - CW'(1);

	// engine sequencing and ram port muxing
	always_comb begin
		mode_d = mode_q;
		idx_d  = idx_q;
		issue  = 1'b0;
		raddr  = idx_q[IW-1:0];
		we     = 1'b0;
		waddr  = pos_q[IW-1:0];
		wdata  = {base_q, len_q};
		unique case (mode_q)
			MODE_NONE: issue = 1'b0;
			MODE_SCAN: begin
				if (stop_now) begin
					mode_d = MODE_NONE;
				end else if (idx_q < count_q) begin
					issue = 1'b1;
					idx_d = idx_q + CW'(1);
				end else if (!rd_valid_s1) begin
					mode_d = MODE_NONE;
				end
			end
			MODE_UP: begin
				// close the gap: entry j+1 moves to j
				if (rd_valid_s1) begin
					we    = 1'b1;
					waddr = rd_idx_s1 - IW'(1);
					wdata = rdata;
				end
				if (idx_q < count_q) begin
					issue = 1'b1;
					idx_d = idx_q + CW'(1);
				end else if (!rd_valid_s1) begin
					mode_d = MODE_NONE;
				end
			end
			MODE_DOWN: begin
				// open a slot: entry j moves to j+1, from the tail down
				raddr = idx_m1[IW-1:0];
				if (rd_valid_s1) begin
					we    = 1'b1;
					waddr = rd_idx_s1 + IW'(1);
					wdata = rdata;
				end
				if (idx_q > pos_q) begin
					issue = 1'b1;
					idx_d = idx_m1;
				end else if (!rd_valid_s1) begin
					mode_d = MODE_NONE;
				end
			end
			default: mode_d = MODE_NONE;
		endcase
		if (cmd.write_new) begin
			we    = 1'b1;
			waddr = pos_q[IW-1:0];
			wdata = {base_q, len_q};
		end
		if (cmd.start_scan) begin
			mode_d = MODE_SCAN;
			idx_d  = '0;
		end else if (cmd.start_dn) begin
			mode_d = MODE_DOWN;
			idx_d  = count_q;
		end else if (cmd.start_up) begin
			mode_d = MODE_UP;
			idx_d  = pos_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			rd_valid_s1 <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			mode_q      <= mode_d;
			rd_valid_s1 <= issue;
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		rd_idx_s1 <= raddr;
		if (cmd.latch_req) begin
			kind_q      <= req.kind;
			base_q      <= req.prefix_base;
			len_q       <= req.prefix_length;
			addr_q      <= req.address;
			hit_q       <= 1'b0;
			hit_len_q   <= '0;
		end
		if (cmd.start_scan) begin
			pos_q       <= count_q;
			pos_found_q <= 1'b0;
		end
		if (stop_now) begin
			hit_q     <= 1'b1;
			hit_len_q <= ent.len;
			pos_q     <= CW'(rd_idx_s1);
		end else if (shorter) begin
			pos_found_q <= 1'b1;
			pos_q       <= CW'(rd_idx_s1);
		end
		if (cmd.load_rsp) begin
			rsp_status_q <= cmd.status;
			rsp_found_q  <= (kind_q == KIND_CHECK) && hit_q;
			rsp_mlen_q   <= ((kind_q == KIND_CHECK) && hit_q) ? hit_len_q : '0;
		end
	end

	assign sts.kind       = kind_q;
	assign sts.len_bad    = (len_q > LEN_MAX);
	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q == CW'(TABLE_DEPTH));
	assign sts.busy       = (mode_q != MODE_NONE);
	assign sts.hit        = hit_q;
	assign sts.rsp_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid        = rsp_valid_q;
	assign rsp_status       = rsp_status_q;
	assign rsp_found        = rsp_found_q;
	assign rsp_match_length = rsp_mlen_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_grow_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> (count_q < CW'(TABLE_DEPTH)) && (mode_q == MODE_NONE))
		else $error("insert into full table or while engine busy");

	a_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write_new || cmd.count_dec) |-> !rd_valid_s1)
		else $error("table update overlaps a pending ram read");

	a_rsp_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |=> rsp_valid_q)
		else $error("result not presented after load");
`endif
endmodule

>>> test/iptl_lpm_checker.sv
// checker of the ipv4 prefix table: predicts each result and compares it with the block
`timescale 1ns / 1ps

module iptl_lpm_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	iptl_req_if  req,
	iptl_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);
	import iptl_pkg::*;

	typedef struct packed {
		status_t          status;
		logic             found;
		logic [LEN_W-1:0] match_length;
	} lpm_result_t;

	// own copy of the table, longest prefix first
	logic [ADDR_W-1:0] prefix_base_tbl [TABLE_DEPTH];
	logic [LEN_W-1:0]  prefix_len_tbl [TABLE_DEPTH];
	int                prefix_count;
	lpm_result_t       result_q [$];

	function automatic int find_prefix(input logic [ADDR_W-1:0] base,
			input logic [LEN_W-1:0] len);
		int i;
		for (i = 0; i < prefix_count; i++) begin
			if (prefix_base_tbl[i] == base && prefix_len_tbl[i] == len) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic predict_result(
		input  logic [KIND_W-1:0] kind,
		input  logic [ADDR_W-1:0] base,
		input  logic [LEN_W-1:0]  len,
		input  logic [ADDR_W-1:0] addr,
		output lpm_result_t       res
	);
		int                hit;
		int                pos;
		int                i;
		logic [ADDR_W-1:0] mask;
		res.status       = ST_OK;
		res.found        = 1'b0;
		res.match_length = '0;
		hit              = find_prefix(base, len);
		case (kind)
		KIND_ADD: begin
			if (len > LEN_MAX) begin
				res.status = ST_BAD_LEN;
			end else if (hit >= 0) begin
				res.status = ST_MISS;
			end else if (prefix_count >= TABLE_DEPTH) begin
				res.status = ST_CAPACITY;
			end else begin
				// new entry slides up past every strictly shorter one
				pos = prefix_count;
				while (pos > 0 && prefix_len_tbl[pos-1] < len) begin
					prefix_base_tbl[pos] = prefix_base_tbl[pos-1];
					prefix_len_tbl[pos]  = prefix_len_tbl[pos-1];
					pos--;
				end
				prefix_base_tbl[pos] = base;
				prefix_len_tbl[pos]  = len;
				prefix_count++;
			end
		end
		KIND_DEL: begin
			if (len > LEN_MAX) begin
				res.status = ST_BAD_LEN;
			end else if (prefix_count == 0) begin
				res.status = ST_CAPACITY;
			end else if (hit < 0) begin
				res.status = ST_MISS;
			end else begin
				for (i = hit; i < prefix_count - 1; i++) begin
					prefix_base_tbl[i] = prefix_base_tbl[i+1];
					prefix_len_tbl[i]  = prefix_len_tbl[i+1];
				end
				prefix_count--;
			end
		end
		KIND_CHECK: begin
			// a shift by the full width gives the empty mask of length zero
			for (i = 0; i < prefix_count && !res.found; i++) begin
				mask = {ADDR_W{1'b1}} << (ADDR_W - prefix_len_tbl[i]);
				if ((addr & mask) == prefix_base_tbl[i]) begin
					res.found        = 1'b1;
					res.match_length = prefix_len_tbl[i];
				end
			end
		end
		default: begin
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lpm_result_t want;
		int          errs;
		errs = 0;
		if (!arst_n) begin
			prefix_count = 0;
			result_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: status %0d found %0d match_length %0d",
						rsp.status, rsp.found, rsp.match_length);
					errs++;
				end else begin
					want = result_q.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errs++;
					end
					if (rsp.match_length !== want.match_length) begin
						$error("match_length: expected %0d, got %0d",
							want.match_length, rsp.match_length);
						errs++;
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_result(req.kind, req.prefix_base, req.prefix_length, req.address, want);
				result_q.push_back(want);
			end
			pending    <= result_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

>>> test/tb_ipv4_prefix_table_lpm.sv
// testbench top of the ipv4 prefix table: request stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_ipv4_prefix_table_lpm;
	import iptl_pkg::*;

	localparam int TABLE_DEPTH    = 64;
	localparam int TOTAL_REQUESTS = 550;
	// receiver hold-off, well above the slowest request so the block backs up
	localparam int HOLD_CYCLES    = 400;
	// longest add or delete stays below this settle time
	localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 16;
	localparam int CYCLE_LIMIT    = 1000000;
	// kind code with no operation behind it
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	// idling knobs, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// long receiver hold-offs asked for and served
	int hold_asks = 0;
	int hold_done = 0;

	int fail_count;
	int results_pending;
	int cycle_count = 0;

	int n_sent   = 0;
	int n_add    = 0;
	int n_del    = 0;
	int n_check  = 0;
	int n_unused = 0;
	int n_full   = 0;
	int n_empty  = 0;

	// prefixes currently stored, kept only to steer the stimulus
	logic [ADDR_W-1:0] pool_base [$];
	logic [LEN_W-1:0]  pool_len [$];

	iptl_req_if req ();
	iptl_rsp_if rsp ();

	ipv4_prefix_table_lpm #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	iptl_lpm_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) lpm_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_ipv4_prefix_table_lpm: done, errors");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_done) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// n most significant bits set, for lengths 0..32
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		return {ADDR_W{1'b1}} << (ADDR_W - len);
	endfunction

	function automatic int pool_find(input logic [ADDR_W-1:0] base,
			input logic [LEN_W-1:0] len);
		int i;
		for (i = 0; i < pool_base.size(); i++) begin
			if (pool_base[i] == base && pool_len[i] == len) begin
				return i;
			end
		end
		return -1;
	endfunction

	// lengths bunch on a few values so equal lengths pile up in the table
	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(9))
		0:       return 6'd0;
		1:       return 6'd1;
		2:       return 6'd8;
		3:       return 6'd16;
		4:       return 6'd24;
		5:       return 6'd31;
		6:       return LEN_MAX;
		default: return LEN_W'($urandom_range(32));
		endcase
	endfunction

	// offer one request, wait for the handshake, then track the stored set
	task automatic send_item(
		input logic [KIND_W-1:0] kind,
		input logic [ADDR_W-1:0] base,
		input logic [LEN_W-1:0]  len,
		input logic [ADDR_W-1:0] addr
	);
		int idx;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.kind          <= kind;
		req.prefix_base   <= base;
		req.prefix_length <= len;
		req.address       <= addr;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
		idx = pool_find(base, len);
		case (kind)
		KIND_ADD: begin
			n_add++;
			if (len <= LEN_MAX && idx < 0) begin
				if (pool_base.size() < TABLE_DEPTH) begin
					pool_base.push_back(base);
					pool_len.push_back(len);
				end else begin
					n_full++;
				end
			end
		end
		KIND_DEL: begin
			n_del++;
			if (len <= LEN_MAX) begin
				if (pool_base.size() == 0) begin
					n_empty++;
				end else if (idx >= 0) begin
					pool_base.delete(idx);
					pool_len.delete(idx);
				end
			end
		end
		KIND_CHECK: begin
			n_check++;
		end
		default: begin
		n_unused++;
		end
		endcase
	endtask

	// hold the sender until every result is back, with nothing offered meanwhile
	task automatic await_results();
		req.valid <= 1'b0;
		@(posedge clk);
		wait (results_pending == 0);
		@(posedge clk);
	endtask

	task automatic random_item();
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] noise;
		logic [LEN_W-1:0]  len;
		int                pick;
		int                idx;
		base  = $urandom();
		addr  = $urandom();
		noise = $urandom();
		len   = pick_len();
		pick  = $urandom_range(99);
		idx   = (pool_base.size() > 0) ? $urandom_range(pool_base.size() - 1) : -1;
		if (pick < 36) begin
			// add: mostly clean bases, some with host bits, some repeats
			if ($urandom_range(9) < 7) begin
				base = base & len_mask(len);
			end else if (idx >= 0 && $urandom_range(1)) begin
				base = pool_base[idx];
				len  = pool_len[idx];
			end
			send_item(KIND_ADD, base, len, addr);
		end else if (pick < 56) begin
			// delete: mostly a stored prefix, else most likely absent
			if (idx >= 0 && $urandom_range(9) < 7) begin
				base = pool_base[idx];
				len  = pool_len[idx];
			end
			send_item(KIND_DEL, base, len, addr);
		end else if (pick < 94) begin
			// check: an address under a stored prefix, or anywhere
			if (idx >= 0 && $urandom_range(3) != 0) begin
				addr = pool_base[idx] | (noise & ~len_mask(pool_len[idx]));
			end
			send_item(KIND_CHECK, base, len, addr);
		end else if (pick < 97) begin
			// lengths past 32
			send_item(pick[0] ? KIND_ADD : KIND_DEL, base,
				LEN_W'($urandom_range(63, 33)), addr);
		end else begin
			send_item(KIND_UNUSED, base, LEN_W'($urandom()), addr);
		end
	endtask

	// add fresh prefixes until the table is full, then poke at the full table
	task automatic fill_table();
		logic [LEN_W-1:0] len;
		int               idx;
		while (pool_base.size() < TABLE_DEPTH) begin
			len = LEN_W'($urandom_range(32, 1));
			send_item(KIND_ADD, $urandom() & len_mask(len), len, $urandom());
		end
		// a new prefix is refused for room, a duplicate is refused as such
		send_item(KIND_ADD, $urandom(), LEN_MAX, $urandom());
		idx = $urandom_range(TABLE_DEPTH - 1);
		send_item(KIND_ADD, pool_base[idx], pool_len[idx], $urandom());
		repeat (4) begin
			idx = $urandom_range(TABLE_DEPTH - 1);
			send_item(KIND_CHECK, $urandom(), pick_len(),
				pool_base[idx] | ($urandom() & ~len_mask(pool_len[idx])));
		end
	endtask

	// delete every stored prefix in random order, then hit the empty table
	task automatic drain_table();
		int idx;
		while (pool_base.size() > 0) begin
			idx = $urandom_range(pool_base.size() - 1);
			send_item(KIND_DEL, pool_base[idx], pool_len[idx], $urandom());
		end
		send_item(KIND_DEL, $urandom(), pick_len(), $urandom());
		send_item(KIND_CHECK, $urandom(), pick_len(), $urandom());
	endtask

	initial begin
		req.valid         <= 1'b0;
		req.kind          <= KIND_ADD;
		req.prefix_base   <= '0;
		req.prefix_length <= '0;
		req.address       <= '0;
		arst_n            <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests, no idling
		// empty table: lookup misses, delete finds nothing, bad length wins over empty
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'hC0A8_0101);
		send_item(KIND_DEL, 32'h0000_0000, 6'd0, $urandom());
		send_item(KIND_DEL, $urandom(), 6'd33, $urandom());
		// extremes of length and base
		send_item(KIND_ADD, 32'hFFFF_FFFF, LEN_MAX, $urandom());
		send_item(KIND_ADD, 32'h0000_0000, 6'd0, $urandom());
		// base with host bits is kept as given and never matches
		send_item(KIND_ADD, 32'h0A00_0001, 6'd8, $urandom());
		send_item(KIND_ADD, $urandom(), 6'd63, $urandom());
		send_item(KIND_ADD, $urandom(), 6'd33, $urandom());
		// duplicate
		send_item(KIND_ADD, 32'h0000_0000, 6'd0, $urandom());
		send_item(KIND_ADD, 32'h0A00_0000, 6'd8, $urandom());
		send_item(KIND_ADD, 32'h0A12_0000, 6'd16, $urandom());
		// full mask reaches bit 0
		send_item(KIND_ADD, 32'h8000_0001, LEN_MAX, $urandom());
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'hFFFF_FFFF);
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'h0A12_3456);
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'h0A00_0001);
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'h8000_0000);
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'h8000_0001);
		// delete: wrong length, exact match, bad length
		send_item(KIND_DEL, 32'h0A00_0000, 6'd9, $urandom());
		send_item(KIND_DEL, 32'h0A00_0000, 6'd8, $urandom());
		send_item(KIND_DEL, 32'h0A12_3456, 6'd63, $urandom());
		send_item(KIND_UNUSED, $urandom(), LEN_W'($urandom()), $urandom());
		// without the default route the lookups can miss again
		send_item(KIND_DEL, 32'h0000_0000, 6'd0, $urandom());
		send_item(KIND_CHECK, $urandom(), 6'd0, 32'h0B00_0000);

		// no idling, receiver holds off while requests keep coming
		hold_asks++;
		repeat (40) random_item();

		// sender idles
		send_idle_pct = 51;
		repeat (110) random_item();
		fill_table();
		await_results();

		// receiver stalls
		send_idle_pct  = 0;
		recv_stall_pct = 51;
		repeat (110) random_item();
		drain_table();

		// both sides idle
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		while (n_sent < TOTAL_REQUESTS - 40) random_item();

		// closing stretch at full rate
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (n_sent < TOTAL_REQUESTS) random_item();

		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (results_pending != 0) begin
			$error("%0d results never arrived", results_pending);
		end
		$display("covered %0d requests: %0d add, %0d delete, %0d check, %0d unused kind",
			n_sent, n_add, n_del, n_check, n_unused);
		$display("adds refused for a full table: %0d, deletes on an empty table: %0d",
			n_full, n_empty);
		if (fail_count == 0 && results_pending == 0) begin
			$display("tb_ipv4_prefix_table_lpm: done, clean");
		end else begin
			$display("tb_ipv4_prefix_table_lpm: done, errors");
		end
		$finish;
	end

endmodule
